// ===== hdl/sem_pkg.sv =====
// Shared types, constants and the square-root step for the Sobel edge magnitude block.
// No dependencies; every other file in hdl/ imports this package.
package sem_pkg;

   // Geometry and configuration
   localparam int DEFAULT_MAX_WIDTH = 2048;
   localparam int PIXEL_W           = 8;
   localparam int DIM_W             = 12;
   localparam int MIN_DIM           = 3;
   localparam int HEIGHT_LIMIT      = 2048;
   localparam int ROW_W             = 11;
   localparam int RESET_WIDTH       = 1920;
   localparam int RESET_HEIGHT      = 1080;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;

   // Window queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Arithmetic widths
   localparam int GRAD_W      = 10;
   localparam int SQ_W        = 20;
   localparam int SUM_W       = 21;
   localparam int NORM_SHIFT  = 5;
   localparam int RAD_W       = 16;
   localparam int ROOT_W      = 8;
   localparam int REM_W       = 10;
   localparam int SQRT_STAGES = 4;
   localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // One 3x3 window, index row*3+col, row 0 oldest, col 0 leftmost
   typedef struct packed {
      logic [8:0][PIXEL_W-1:0] win;
      logic                    last;
   } win_item_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_state_type;

   // One digit of the restoring square root: bring down a bit pair, try 4*root+1
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type cur,
                                                input logic [1:0] pair);
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      sqrt_state_type   res;
      acc   = {cur.rem, pair};
      trial = (REM_W+2)'({cur.root, 2'b01});
      if (acc >= trial) begin
         res.rem  = REM_W'(acc - trial);
         res.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         res.rem  = acc[REM_W-1:0];
         res.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// ===== hdl/sem_queue.sv =====
// Short window queue that decouples the front (line stores) from the back (arithmetic).
// Depends on sem_pkg for the item type and depth.
module sem_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sem_pkg::win_item_type push_item,
   input  logic                 pop,
   output sem_pkg::win_item_type pop_item,
   output logic                 empty,
   output logic [sem_pkg::QCNT_W-1:0] count
);
   import sem_pkg::*;

   win_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   // Advance pointers with explicit wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the window
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QUEUE_DEPTH)))
      else $error("window queue overflow");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("window queue underflow");
`endif

endmodule

// ===== hdl/sem_front.sv =====
// Front end: accepts pixels, tracks the raster position, keeps the two line stores
// and the 3x3 window, and pushes windows of interior pixels. Depends on sem_pkg.
module sem_front #(
   parameter int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sem_pkg::PIXEL_W-1:0]  req_pixel,
   input  logic [sem_pkg::DIM_W-1:0]    image_width,
   input  logic [sem_pkg::DIM_W-1:0]    image_height,
   input  logic [sem_pkg::QCNT_W-1:0]   q_count,
   output logic                         push,
   output sem_pkg::win_item_type        push_item
);
   import sem_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CW    = COL_W + 1;

   logic                 accept;
   logic [CW-1:0]        w_eff;
   logic [DIM_W-1:0]     h_eff;
   logic [CW-1:0]        col_cur;
   logic [DIM_W-1:0]     row_cur;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 emit, last;

   logic                 f1_valid_ff;
   logic [PIXEL_W-1:0]   f1_pixel_ff;
   logic [COL_W-1:0]     f1_col_ff;
   logic                 f1_emit_ff;
   logic                 f1_last_ff;

   // Both line stores share one address: upper in the high byte, middle in the low byte
   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;

   logic [8:0][PIXEL_W-1:0] win_ff, win_in;

   // Hold off while the queue could not take this pixel's window next cycle
   assign req_ready = (q_count + QCNT_W'(f1_valid_ff)) < QCNT_W'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // Clamp frame dimensions
   always_comb begin
      if (image_width < DIM_W'(MIN_DIM)) begin
         w_eff = CW'(MIN_DIM);
      end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(image_width);
      end
      if (image_height < DIM_W'(MIN_DIM)) begin
         h_eff = DIM_W'(MIN_DIM);
      end else if (image_height > DIM_W'(HEIGHT_LIMIT)) begin
         h_eff = DIM_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = image_height;
      end
   end

   // Resolve the current position, wrapping if the frame shrank, then advance
   always_comb begin
      if (CW'(col_ff) >= w_eff) begin
         col_cur = '0;
         row_cur = DIM_W'(row_ff) + 1'b1;
      end else begin
         col_cur = CW'(col_ff);
         row_cur = DIM_W'(row_ff);
      end
      if (row_cur >= h_eff) begin
         row_cur = '0;
      end
      if (col_cur + 1'b1 >= w_eff) begin
         col_in = '0;
         row_in = (row_cur + 1'b1 >= h_eff) ? '0 : ROW_W'(row_cur + 1'b1);
      end else begin
         col_in = COL_W'(col_cur + 1'b1);
         row_in = ROW_W'(row_cur);
      end
      emit = (row_cur >= DIM_W'(2)) && (col_cur >= CW'(2));
      last = (row_cur == h_eff - 1'b1) && (col_cur == w_eff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         f1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_pixel_ff <= req_pixel;
         f1_col_ff   <= COL_W'(col_cur);
         f1_emit_ff  <= emit;
         f1_last_ff  <= last;
      end
   end

   // Read the column on accept, write it back shifted up one row in the next cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[COL_W'(col_cur)];
      end
      if (f1_valid_ff) begin
         line_mem[f1_col_ff] <= {rd_data_ff[PIXEL_W-1:0], f1_pixel_ff};
      end
   end

   // Shift the window left and bring in the new column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3+1];
         win_in[r*3+1]   = win_ff[r*3+2];
      end
      win_in[2] = rd_data_ff[2*PIXEL_W-1:PIXEL_W];
      win_in[5] = rd_data_ff[PIXEL_W-1:0];
      win_in[8] = f1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (f1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   assign push           = f1_valid_ff && f1_emit_ff;
   assign push_item.win  = win_in;
   assign push_item.last = f1_last_ff;

`ifndef SYNTHESIS
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !req_ready)
      else $error("front accepts while window queue is full");
`endif

endmodule

// ===== hdl/sem_back.sv =====
// Back end: Sobel gradients, squared sum, scaling and a pipelined square root,
// ending in the result register. Depends on sem_pkg.
module sem_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  sem_pkg::win_item_type       q_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sem_pkg::ROOT_W-1:0]  rsp_magnitude,
   output logic                        rsp_last_of_frame
);
   import sem_pkg::*;

   logic adv;

   logic [GRAD_W-1:0] a_pos, a_neg, b_pos, b_neg;
   logic [SUM_W-1:0]  sum;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff;
   logic [GRAD_W-1:0] s1_abs_a_ff, s1_abs_b_ff;
   logic [SQ_W-1:0]   s2_sq_a_ff, s2_sq_b_ff;
   logic [RAD_W-1:0]  s3_rad_ff;

   logic [RAD_W-1:0]  sq_rad_ff  [SQRT_STAGES];
   logic [REM_W-1:0]  sq_rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] sq_root_ff [SQRT_STAGES];
   logic              sq_valid_ff[SQRT_STAGES];
   logic              sq_last_ff [SQRT_STAGES];

   logic [RAD_W-1:0]  sq_rad_in  [SQRT_STAGES];
   logic [REM_W-1:0]  sq_rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0] sq_root_in [SQRT_STAGES];

   logic              rsp_valid_ff;
   logic [ROOT_W-1:0] rsp_mag_ff;
   logic              rsp_last_ff;

   // Whole pipeline moves together whenever the result register is free
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !q_empty;

   // Kernel taps: gx rows (1 2 1 / 0 0 0 / -1 -2 -1), gy columns (1 0 -1 / 2 0 -2 / 1 0 -1)
   always_comb begin
      a_pos = GRAD_W'(q_item.win[0]) + (GRAD_W'(q_item.win[1]) << 1) + GRAD_W'(q_item.win[2]);
      a_neg = GRAD_W'(q_item.win[6]) + (GRAD_W'(q_item.win[7]) << 1) + GRAD_W'(q_item.win[8]);
      b_pos = GRAD_W'(q_item.win[0]) + (GRAD_W'(q_item.win[3]) << 1) + GRAD_W'(q_item.win[6]);
      b_neg = GRAD_W'(q_item.win[2]) + (GRAD_W'(q_item.win[5]) << 1) + GRAD_W'(q_item.win[8]);
      sum   = SUM_W'(s2_sq_a_ff) + SUM_W'(s2_sq_b_ff);
   end

   // Square root stages, two result bits each
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      logic [RAD_W-1:0]  rad_in;
      logic [RAD_W-1:0]  rad_out;
      sqrt_state_type    st_in;
      sqrt_state_type    st_out;

      if (g == 0) begin : g_first
         assign rad_in      = s3_rad_ff;
         assign st_in.rem   = '0;
         assign st_in.root  = '0;
      end else begin : g_next
         assign rad_in      = sq_rad_ff[g-1];
         assign st_in.rem   = sq_rem_ff[g-1];
         assign st_in.root  = sq_root_ff[g-1];
      end

      always_comb begin
         st_out  = st_in;
         rad_out = rad_in;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            st_out  = sqrt_step(st_out, rad_out[RAD_W-1 -: 2]);
            rad_out = rad_out << 2;
         end
      end

      assign sq_rad_in[g]  = rad_out;
      assign sq_rem_in[g]  = st_out.rem;
      assign sq_root_in[g] = st_out.root;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < SQRT_STAGES; g++) begin
            sq_valid_ff[g] <= 1'b0;
         end
      end else if (adv) begin
         s1_valid_ff    <= !q_empty;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         sq_valid_ff[0] <= s3_valid_ff;
         for (int g = 1; g < SQRT_STAGES; g++) begin
            sq_valid_ff[g] <= sq_valid_ff[g-1];
         end
         rsp_valid_ff   <= sq_valid_ff[SQRT_STAGES-1];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_abs_a_ff <= (a_pos >= a_neg) ? a_pos - a_neg : a_neg - a_pos;
         s1_abs_b_ff <= (b_pos >= b_neg) ? b_pos - b_neg : b_neg - b_pos;
         s1_last_ff  <= q_item.last;
         s2_sq_a_ff  <= SQ_W'(s1_abs_a_ff) * SQ_W'(s1_abs_a_ff);
         s2_sq_b_ff  <= SQ_W'(s1_abs_b_ff) * SQ_W'(s1_abs_b_ff);
         s2_last_ff  <= s1_last_ff;
         s3_rad_ff   <= RAD_W'(sum >> NORM_SHIFT);
         s3_last_ff  <= s2_last_ff;
         sq_last_ff[0] <= s3_last_ff;
         for (int g = 0; g < SQRT_STAGES; g++) begin
            sq_rad_ff[g]  <= sq_rad_in[g];
            sq_rem_ff[g]  <= sq_rem_in[g];
            sq_root_ff[g] <= sq_root_in[g];
         end
         for (int g = 1; g < SQRT_STAGES; g++) begin
            sq_last_ff[g] <= sq_last_ff[g-1];
         end
         rsp_mag_ff  <= sq_root_ff[SQRT_STAGES-1];
         rsp_last_ff <= sq_last_ff[SQRT_STAGES-1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_magnitude     = rsp_mag_ff;
   assign rsp_last_of_frame = rsp_last_ff;

`ifndef SYNTHESIS
   a_pop_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_valid_ff)
      else $error("popped window did not enter the gradient stage");
   a_freeze_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sq_valid_ff[SQRT_STAGES-1]) && $stable(s1_valid_ff))
      else $error("back pipeline moved while result was stalled");
`endif

endmodule

// ===== hdl/sobel_edge_magnitude.sv =====
// Sobel edge magnitude over a raster stream of 8-bit greyscale pixels.
// Usage:
//   req_* takes one pixel per transaction, raster order from frame start.
//   rsp_* gives floor(sqrt((gx^2 + gy^2) / 32)) for each interior pixel (not
//   first/last row or column) in raster order; rsp_last_of_frame marks the
//   final interior pixel of a frame. Border pixels produce no transaction.
//   csr_* is an APB-style port: image_width at 0x0, image_height at 0x4,
//   clamped to [3, MAX_WIDTH] and [3, 2048]. Write only while the block is idle.
// Timing:
//   Sustains one pixel per clock while results are taken. Each result passes
//   through line-store read, window update, queue, gradient, square, scale,
//   four square-root stages of two bits each and the result register, from the
//   pixel that completes its window (the pixel below-right of the center).
//   A stalled receiver freezes the arithmetic pipeline; the four-entry window
//   queue then fills and req_ready drops until results drain.
// Reset:
//   Position returns to frame start, registers to 1920 x 1080. Line stores are
//   not cleared; rows 0 and 1 read stale data, but push no windows.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sem_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sem_pkg::ROOT_W-1:0]      rsp_magnitude,
   output logic                            rsp_last_of_frame,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sem_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sem_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sem_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import sem_pkg::*;

   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   csr_index_type    csr_index;

   logic             push;
   win_item_type     push_item;
   logic             pop;
   win_item_type     pop_item;
   logic             q_empty;
   logic [QCNT_W-1:0] q_count;

   // Decode the register by word address
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(RESET_WIDTH);
         height_ff <= DIM_W'(RESET_HEIGHT);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_pwdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         CSR_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel    (req_pixel),
      .image_width  (width_ff),
      .image_height (height_ff),
      .q_count      (q_count),
      .push         (push),
      .push_item    (push_item)
   );

   sem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (q_empty),
      .count     (q_count)
   );

   sem_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_item            (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
